/* design/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg: shared types and codes of the ordered list engine
// Action and status codes and the queue entry that links front and back.
// ----------------------------------------------------------------------------
`default_nettype none
package ole_pkg;

  typedef enum logic [3:0] {
    ACT_GET    = 4'd0,
    ACT_SET    = 4'd1,
    ACT_APPEND = 4'd2,
    ACT_INSERT = 4'd3,
    ACT_REMOVE = 4'd4,
    ACT_REMVAL = 4'd5,
    ACT_FIND   = 4'd6,
    ACT_CLEAR  = 4'd7,
    ACT_COUNT  = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOB      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned ACTION_BITS = 4;
  localparam int unsigned POS_BITS    = 7;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned FIDX_BITS   = 6;
  localparam int unsigned CNT_BITS    = 7;

  // classified request passed from front to back
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [POS_BITS-1:0]    position;
    logic [WORD_BITS-1:0]   item_value;
  } req_t;

endpackage
`default_nettype wire

/* design/ole_chan_if.sv */
// ----------------------------------------------------------------------------
// ole_req_if / ole_rsp_if: valid/ready channels of the ordered list engine
// Request carries action, position and item; result carries the answer.
// ----------------------------------------------------------------------------
`default_nettype none
interface ole_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [6:0]  position;
  logic [31:0] item_value;
  modport source (output valid, output action, output position, output item_value,
                  input ready);
  modport sink   (input valid, input action, input position, input item_value,
                  output ready);
endinterface

interface ole_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] item_out;
  logic [5:0]  found_index;
  logic [6:0]  entry_count;
  modport source (output valid, output status, output item_out, output found_index,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input item_out, input found_index,
                  input entry_count, output ready);
endinterface
`default_nettype wire

/* design/ole_front.sv */
// ----------------------------------------------------------------------------
// ole_front: request intake and queue
// Accepts items from the input channel into a two-entry queue for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module ole_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ole_req_if.sink          in_ch,
  output ole_pkg::req_t    q_req,
  output logic             q_valid,
  input  wire logic        q_pop
);
  ole_pkg::req_t slot_r [2];
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       push_head;

  assign in_ch.ready = (fill_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (fill_r != 2'd0);
  assign q_req   = slot_r[0];
  // a new item lands in the head slot when the queue is empty after the pop
  assign push_head = push && ((fill_r - {1'b0, q_pop}) == 2'd0);

  // occupancy
  always_comb begin
    fill_nxt = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // storage, shift on pop
  always_ff @(posedge clk) begin
    if (push_head) begin
      slot_r[0] <= '{in_ch.action, in_ch.position, in_ch.item_value};
    end else if (q_pop) begin
      slot_r[0] <= slot_r[1];
    end
    if (push && !push_head) begin
      slot_r[1] <= '{in_ch.action, in_ch.position, in_ch.item_value};
    end
  end

  as_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r != 2'd3)
    else $error("queue overfilled");
  as_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  as_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd2 && !q_pop) |=> fill_r == 2'd2)
    else $error("full queue lost an item");
endmodule
`default_nettype wire

/* design/ole_back.sv */
// ----------------------------------------------------------------------------
// ole_back: list sequencer
// Executes one request at a time on a two-port entry memory, one entry
// moved or compared per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ole_back #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  ole_pkg::req_t    q_req,
  input  wire logic        q_valid,
  output logic             q_pop,
  ole_rsp_if.source        out_ch
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ole_pkg::POS_BITS;
  localparam int unsigned XW = (CW > PW) ? CW : PW;
  localparam int unsigned WW = ole_pkg::WORD_BITS;
  localparam int unsigned FW = ole_pkg::FIDX_BITS;
  localparam int unsigned NW = ole_pkg::CNT_BITS;
  localparam logic [CW-1:0] LIM_RST = CW'((CAPACITY < 64) ? CAPACITY : 64);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_GETW, S_SHUP, S_INSV, S_RMST, S_SHDN, S_SRCH, S_DONE
  } state_t;

  // entry memory, one write and one registered read per cycle
  logic [ITEM_BITS-1:0] mem [CAPACITY];
  logic [ITEM_BITS-1:0] rdata_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [ITEM_BITS-1:0] mem_wdata;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        limit_r;
  logic [AW-1:0]        idx_r, idx_nxt;
  ole_pkg::req_t        req_r, req_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [WW-1:0]        item_r, item_nxt;
  logic [FW-1:0]        fidx_r, fidx_nxt;

  // operands widened for compares
  logic [XW-1:0]        pos_x, cnt_x, idx_x, lim_x;
  logic [AW-1:0]        pos_a, cnt_a;
  logic [ITEM_BITS-1:0] val;
  logic [CW-1:0]        cfg_lim;

  assign pos_x   = XW'(req_r.position);
  assign cnt_x   = XW'(count_r);
  assign idx_x   = XW'(idx_r);
  assign lim_x   = XW'(limit_r);
  assign pos_a   = AW'(pos_x);
  assign cnt_a   = AW'(cnt_x);
  assign val     = ITEM_BITS'(req_r.item_value);
  assign cfg_lim = (XW'(cfg_wdata) > XW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cfg_wdata);

  assign q_pop = (state_r == S_IDLE) && q_valid && !out_valid_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = st_r;
  assign out_ch.item_out    = item_r;
  assign out_ch.found_index = fidx_r;
  assign out_ch.entry_count = NW'(count_r);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // sequencer next state and memory control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    st_nxt        = st_r;
    item_nxt      = item_r;
    fidx_nxt      = fidx_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_raddr     = '0;
    mem_wdata     = val;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          req_nxt   = q_req;
          st_nxt    = ole_pkg::ST_OK;
          item_nxt  = '0;
          fidx_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (req_r.action) inside
          ole_pkg::ACT_GET: begin
            if (pos_x >= cnt_x) st_nxt = ole_pkg::ST_OOB;
            else begin
              mem_re    = 1'b1;
              mem_raddr = pos_a;
              state_nxt = S_GETW;
            end
          end
          ole_pkg::ACT_SET, ole_pkg::ACT_APPEND, ole_pkg::ACT_INSERT: begin
            if (req_r.action == ole_pkg::ACT_APPEND || pos_x == cnt_x) begin
              // append at the end of the list
              if (cnt_x >= lim_x) st_nxt = ole_pkg::ST_FULL;
              else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_a;
                count_nxt = count_r + CW'(1);
              end
            end else if (pos_x > cnt_x) begin
              st_nxt = ole_pkg::ST_OOB;
            end else if (req_r.action == ole_pkg::ACT_SET) begin
              mem_we    = 1'b1;
              mem_waddr = pos_a;
            end else if (cnt_x >= lim_x) begin
              st_nxt = ole_pkg::ST_FULL;
            end else begin
              // open a gap: move the last entry up first
              mem_re    = 1'b1;
              mem_raddr = AW'(cnt_x - XW'(1));
              idx_nxt   = cnt_a;
              state_nxt = S_SHUP;
            end
          end
          ole_pkg::ACT_REMOVE: begin
            if (pos_x >= cnt_x) st_nxt = ole_pkg::ST_OOB;
            else begin
              idx_nxt   = pos_a;
              state_nxt = S_RMST;
            end
          end
          ole_pkg::ACT_REMVAL, ole_pkg::ACT_FIND: begin
            if (count_r == '0) st_nxt = ole_pkg::ST_NOTFOUND;
            else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_nxt   = '0;
              state_nxt = S_SRCH;
            end
          end
          ole_pkg::ACT_CLEAR: count_nxt = '0;
          default: ;
        endcase
      end
      S_GETW: begin
        item_nxt  = WW'(rdata_r);
        state_nxt = S_DONE;
      end
      S_SHUP: begin
        // rdata holds entry idx-1, store it at idx
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rdata_r;
        if (idx_x - XW'(1) == pos_x) state_nxt = S_INSV;
        else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_x - XW'(2));
          idx_nxt   = AW'(idx_x - XW'(1));
        end
      end
      S_INSV: begin
        mem_we    = 1'b1;
        mem_waddr = pos_a;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_RMST: begin
        // remove entry idx; start pulling later entries down
        if (idx_x + XW'(1) >= cnt_x) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_x + XW'(1));
          state_nxt = S_SHDN;
        end
      end
      S_SHDN: begin
        // rdata holds entry idx+1, store it at idx
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rdata_r;
        if (idx_x + XW'(2) >= cnt_x) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_x + XW'(2));
          idx_nxt   = AW'(idx_x + XW'(1));
        end
      end
      S_SRCH: begin
        // rdata holds entry idx
        if (rdata_r == val) begin
          fidx_nxt  = FW'(idx_r);
          state_nxt = (req_r.action == ole_pkg::ACT_REMVAL) ? S_RMST : S_DONE;
        end else if (idx_x + XW'(1) >= cnt_x) begin
          st_nxt    = ole_pkg::ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_x + XW'(1));
          idx_nxt   = AW'(idx_x + XW'(1));
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= LIM_RST;
      idx_r       <= '0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      st_r        <= ole_pkg::ST_OK;
      item_r      <= '0;
      fidx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      item_r      <= item_nxt;
      fidx_r      <= fidx_nxt;
      if (cfg_we) limit_r <= cfg_lim;
    end
  end

  as_cnt: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(CAPACITY))
    else $error("count above capacity");
  as_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_EXEC) else $error("pop without work");
  as_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable({st_r, item_r, fidx_r, count_r})))
    else $error("result dropped or changed");
  as_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r) else $error("result pending while busy");
endmodule
`default_nettype wire

/* design/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine: fixed-capacity ordered list of item words
// Top level joining the request queue and the list sequencer.
// ----------------------------------------------------------------------------
// One item at a time is executed on a two-port entry memory that moves or
// compares one entry per cycle. Set, append, clear, count and unused codes
// make no pass over the entries, get reads one entry, insert and remove
// shift the tail of the list, find compares entries from the head, and
// remove by value compares entries and then moves the entries behind the
// match. The next item starts only after the result is taken; two more
// items wait in the intake queue. Write the capacity only while no item
// is in flight.
// No clearing pass after reset; only entries below the count are ever read.
`default_nettype none
module ordered_list_engine #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  ole_req_if.sink         in_ch,
  ole_rsp_if.source       out_ch
);
  ole_pkg::req_t q_req;
  logic          q_valid, q_pop;

  // intake queue
  ole_front u_front (
    .clk, .rst_n, .in_ch, .q_req, .q_valid, .q_pop
  );

  // list sequencer
  ole_back #(.CAPACITY(CAPACITY), .ITEM_BITS(ITEM_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_req, .q_valid, .q_pop, .out_ch
  );
endmodule
`default_nettype wire
